### src/qrs_pkg.sv
// Package for the quadratic root solver.
// Holds field widths, root count codes and the tag types carried by the pipelines.
// No dependencies.
package qrs_pkg;

	localparam int COEF_WIDTH = 16;
	localparam int FRAC_BITS  = 16;
	localparam int ROOT_WIDTH = 34;

	// Discriminant b*b - 4*a*c, signed, with headroom.
	localparam int DISC_W  = 2 * COEF_WIDTH + 3;
	// Non-negative discriminant handed to the square root.
	localparam int SQ_IN_W = 2 * COEF_WIDTH + 2;
	// Root bits of floor(sqrt(D * 2^(2*FRAC_BITS))).
	localparam int SQ_ROOT_W = (SQ_IN_W + 2 * FRAC_BITS) / 2;
	localparam int SQ_OP_W   = 2 * SQ_ROOT_W;
	localparam int SQ_REM_W  = SQ_ROOT_W + 2;

	// -b scaled by 2^FRAC_BITS.
	localparam int NB_W  = COEF_WIDTH + FRAC_BITS + 1;
	// Numerator -b*2^F +/- s, signed, and its magnitude.
	localparam int NUM_W = SQ_ROOT_W + 2;
	localparam int MAG_W = NUM_W - 1;
	// Denominator 2*a, signed, and its magnitude.
	localparam int DEN_SW = COEF_WIDTH + 1;
	localparam int DEN_W  = COEF_WIDTH + 1;
	localparam int DREM_W = DEN_W + 1;

	localparam logic [1:0] CNT_NONE   = 2'd0;
	localparam logic [1:0] CNT_DOUBLE = 2'd1;
	localparam logic [1:0] CNT_TWO    = 2'd2;

	// Side information that travels next to the square root.
	typedef struct packed {
		logic [1:0]               cnt;
		logic                     deg;
		logic signed [NB_W-1:0]   nb;
		logic signed [DEN_SW-1:0] den;
	} sq_tag_t;

	// Side information that travels next to the dividers.
	typedef struct packed {
		logic [1:0] cnt;
		logic       deg;
		logic       neg_p;
		logic       neg_m;
	} dv_tag_t;

endpackage

### src/qrs_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage.
// Computes floor(sqrt(rad * 2^(2*FRAC_BITS))) and carries a tag alongside.
// Depends on qrs_pkg.
module qrs_sqrt_pipe import qrs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [SQ_IN_W-1:0]   rad,
	input  sq_tag_t              in_tag,
	output logic                 out_vld,
	output logic [SQ_ROOT_W-1:0] root,
	output sq_tag_t              out_tag
);

	logic [SQ_OP_W-1:0]   op_s   [0:SQ_ROOT_W];
	logic [SQ_REM_W-1:0]  rem_s  [0:SQ_ROOT_W];
	logic [SQ_ROOT_W-1:0] root_s [0:SQ_ROOT_W];
	logic                 vld_s  [0:SQ_ROOT_W];
	sq_tag_t              tag_s  [0:SQ_ROOT_W];

	// Stage zero is the unregistered input.
	assign op_s[0]   = {rad, {(SQ_OP_W - SQ_IN_W){1'b0}}};
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign vld_s[0]  = in_vld;
	assign tag_s[0]  = in_tag;

	for (genvar k = 0; k < SQ_ROOT_W; k++) begin : g_step
		logic [SQ_REM_W-1:0] rem_sh;
		logic [SQ_REM_W-1:0] trial;
		logic                ge;

		// Bring down two radicand bits and try the next root bit.
		always_comb begin
			rem_sh = {rem_s[k][SQ_REM_W-3:0], op_s[k][SQ_OP_W-1 -: 2]};
			trial  = {root_s[k], 2'b01};
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? rem_sh - trial : rem_sh;
				root_s[k+1] <= {root_s[k][SQ_ROOT_W-2:0], ge};
				op_s[k+1]   <= {op_s[k][SQ_OP_W-3:0], 2'b00};
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	assign out_vld = vld_s[SQ_ROOT_W];
	assign root    = root_s[SQ_ROOT_W];
	assign out_tag = tag_s[SQ_ROOT_W];

endmodule

### src/qrs_div_pipe.sv
// Pipelined restoring divider with two lanes that share one divisor.
// One quotient bit per stage for each lane; magnitudes only.
// Depends on qrs_pkg.
module qrs_div_pipe import qrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [MAG_W-1:0] num_p,
	input  logic [MAG_W-1:0] num_m,
	input  logic [DEN_W-1:0] den,
	input  dv_tag_t          in_tag,
	output logic             out_vld,
	output logic [MAG_W-1:0] quo_p,
	output logic [MAG_W-1:0] quo_m,
	output dv_tag_t          out_tag
);

	logic [MAG_W-1:0]  np_s  [0:MAG_W];
	logic [MAG_W-1:0]  nm_s  [0:MAG_W];
	logic [DREM_W-1:0] rp_s  [0:MAG_W];
	logic [DREM_W-1:0] rm_s  [0:MAG_W];
	logic [MAG_W-1:0]  qp_s  [0:MAG_W];
	logic [MAG_W-1:0]  qm_s  [0:MAG_W];
	logic [DEN_W-1:0]  den_s [0:MAG_W];
	logic              vld_s [0:MAG_W];
	dv_tag_t           tag_s [0:MAG_W];

	assign np_s[0]  = num_p;
	assign nm_s[0]  = num_m;
	assign rp_s[0]  = '0;
	assign rm_s[0]  = '0;
	assign qp_s[0]  = '0;
	assign qm_s[0]  = '0;
	assign den_s[0] = den;
	assign vld_s[0] = in_vld;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < MAG_W; k++) begin : g_step
		logic [DREM_W-1:0] rp_sh;
		logic [DREM_W-1:0] rm_sh;
		logic [DREM_W-1:0] dv;
		logic              ge_p;
		logic              ge_m;

		// Shift in the next numerator bit and subtract where it fits.
		always_comb begin
			dv    = {1'b0, den_s[k]};
			rp_sh = {rp_s[k][DREM_W-2:0], np_s[k][MAG_W-1]};
			rm_sh = {rm_s[k][DREM_W-2:0], nm_s[k][MAG_W-1]};
			ge_p  = rp_sh >= dv;
			ge_m  = rm_sh >= dv;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rp_s[k+1]  <= ge_p ? rp_sh - dv : rp_sh;
				rm_s[k+1]  <= ge_m ? rm_sh - dv : rm_sh;
				qp_s[k+1]  <= {qp_s[k][MAG_W-2:0], ge_p};
				qm_s[k+1]  <= {qm_s[k][MAG_W-2:0], ge_m};
				np_s[k+1]  <= {np_s[k][MAG_W-2:0], 1'b0};
				nm_s[k+1]  <= {nm_s[k][MAG_W-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_vld = vld_s[MAG_W];
	assign quo_p   = qp_s[MAG_W];
	assign quo_m   = qm_s[MAG_W];
	assign out_tag = tag_s[MAG_W];

endmodule

### src/quadratic_root_solver_core.sv
// Quadratic root solver: real roots of a*x^2 + b*x + c in signed fixed point.
// The pipeline has two front stages, 33 square root stages, one numerator
// stage, 34 divider stages and the output register. Throughput is one request
// per cycle; the whole pipeline holds while a finished result is stalled.
// Reset clears all valid bits; data registers are not reset.
module quadratic_root_solver_core import qrs_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COEF_WIDTH-1:0]  coef_a,
	input  logic signed [COEF_WIDTH-1:0]  coef_b,
	input  logic signed [COEF_WIDTH-1:0]  coef_c,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    root_count,
	output logic signed [ROOT_WIDTH-1:0]  root_plus,
	output logic signed [ROOT_WIDTH-1:0]  root_minus,
	output logic                          degenerate
);

	logic adv;

	// The pipeline moves unless the output holds a result that is stalled.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: products b*b and a*c.
	logic                          vld_s1;
	logic signed [2*COEF_WIDTH-1:0] bb_s1;
	logic signed [2*COEF_WIDTH-1:0] ac_s1;
	logic signed [COEF_WIDTH-1:0]  a_s1;
	logic signed [COEF_WIDTH-1:0]  b_s1;
	logic                          deg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s1  <= coef_b * coef_b;
			ac_s1  <= coef_a * coef_c;
			a_s1   <= coef_a;
			b_s1   <= coef_b;
			deg_s1 <= coef_a == '0;
		end
	end

	// Stage 2: discriminant and classification.
	logic signed [DISC_W-1:0] disc;
	logic signed [NB_W-1:0]   b_ext;
	logic                     disc_neg;
	logic                     disc_zero;
	logic                     vld_s2;
	logic [SQ_IN_W-1:0]       rad_s2;
	sq_tag_t                  tag_s2;

	always_comb begin
		disc      = DISC_W'(bb_s1) - (DISC_W'(ac_s1) <<< 2);
		disc_neg  = disc[DISC_W-1];
		disc_zero = disc == '0;
		b_ext     = NB_W'(b_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s2      <= (disc_neg || deg_s1) ? '0 : disc[SQ_IN_W-1:0];
			tag_s2.deg  <= deg_s1;
			tag_s2.cnt  <= (disc_neg || deg_s1) ? CNT_NONE :
				(disc_zero ? CNT_DOUBLE : CNT_TWO);
			tag_s2.nb   <= -(b_ext <<< FRAC_BITS);
			tag_s2.den  <= DEN_SW'(a_s1) <<< 1;
		end
	end

	// Square root of the scaled discriminant.
	logic                 sq_vld;
	logic [SQ_ROOT_W-1:0] sq_root;
	sq_tag_t              sq_tag;

	qrs_sqrt_pipe u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s2),
		.rad     (rad_s2),
		.in_tag  (tag_s2),
		.out_vld (sq_vld),
		.root    (sq_root),
		.out_tag (sq_tag)
	);

	// Stage 3: numerators, their magnitudes and the quotient signs.
	logic signed [NUM_W-1:0] np;
	logic signed [NUM_W-1:0] nm;
	logic signed [NUM_W-1:0] np_abs;
	logic signed [NUM_W-1:0] nm_abs;
	logic signed [DEN_SW-1:0] den_abs;
	logic                    vld_s3;
	logic [MAG_W-1:0]        np_s3;
	logic [MAG_W-1:0]        nm_s3;
	logic [DEN_W-1:0]        den_s3;
	dv_tag_t                 tag_s3;

	always_comb begin
		np      = NUM_W'(sq_tag.nb) + $signed({1'b0, sq_root});
		nm      = NUM_W'(sq_tag.nb) - $signed({1'b0, sq_root});
		np_abs  = np[NUM_W-1] ? -np : np;
		nm_abs  = nm[NUM_W-1] ? -nm : nm;
		den_abs = sq_tag.den[DEN_SW-1] ? -sq_tag.den : sq_tag.den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			np_s3        <= np_abs[MAG_W-1:0];
			nm_s3        <= nm_abs[MAG_W-1:0];
			den_s3       <= den_abs;
			tag_s3.cnt   <= sq_tag.cnt;
			tag_s3.deg   <= sq_tag.deg;
			tag_s3.neg_p <= np[NUM_W-1] ^ sq_tag.den[DEN_SW-1];
			tag_s3.neg_m <= nm[NUM_W-1] ^ sq_tag.den[DEN_SW-1];
		end
	end

	// Both quotients, truncated toward zero by dividing magnitudes.
	logic             dv_vld;
	logic [MAG_W-1:0] quo_p;
	logic [MAG_W-1:0] quo_m;
	dv_tag_t          dv_tag;

	qrs_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s3),
		.num_p   (np_s3),
		.num_m   (nm_s3),
		.den     (den_s3),
		.in_tag  (tag_s3),
		.out_vld (dv_vld),
		.quo_p   (quo_p),
		.quo_m   (quo_m),
		.out_tag (dv_tag)
	);

	// Output register: apply signs, force zero roots where there are none.
	logic [ROOT_WIDTH-1:0] qp_w;
	logic [ROOT_WIDTH-1:0] qm_w;

	always_comb begin
		qp_w = quo_p[ROOT_WIDTH-1:0];
		qm_w = quo_m[ROOT_WIDTH-1:0];
		if (dv_tag.neg_p) begin
			qp_w = -qp_w;
		end
		if (dv_tag.neg_m) begin
			qm_w = -qm_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root_count <= dv_tag.cnt;
			degenerate <= dv_tag.deg;
			root_plus  <= (dv_tag.cnt == CNT_NONE) ? '0 : $signed(qp_w);
			root_minus <= (dv_tag.cnt == CNT_NONE) ? '0 : $signed(qm_w);
		end
	end

`ifndef SYNTHESIS
	// A degenerate result carries no roots.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |->
		(root_count == CNT_NONE && root_plus == '0 && root_minus == '0))
		else $error("degenerate result carries roots");

	// A double root reports the same value twice.
	a_double_same: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && root_count == CNT_DOUBLE) |-> (root_plus == root_minus))
		else $error("double root values differ");

	// An accepted request reaches the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s1)
		else $error("accepted request lost at entry");

	// A stalled result is held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(root_plus)))
		else $error("stalled result changed");
`endif

endmodule
